@@ rtl/bmhq_pkg.sv @@
// shared constants and codes for the binary min-heap queue
package bmhq_pkg;

  // default heap depth in keys
  localparam int unsigned DefaultDepth = 1024;

  // word field widths
  localparam int unsigned KeyW    = 64;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 11;

  // request modes
  localparam logic [ModeW-1:0] MODE_PUSH  = 2'd0;
  localparam logic [ModeW-1:0] MODE_POP   = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

endpackage

@@ rtl/bmhq_ram.sv @@
// heap key store: one write port, one registered read port
module bmhq_ram #(
  parameter int unsigned DEPTH = bmhq_pkg::DefaultDepth,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [bmhq_pkg::KeyW-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [bmhq_pkg::KeyW-1:0] rdata_o
);

  logic [bmhq_pkg::KeyW-1:0] mem_q [DEPTH];
  logic [bmhq_pkg::KeyW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/binary_min_heap_queue_top.sv @@
// top level of the binary min-heap queue: sequencer, shared comparator and key store
//
// Usage: each input word carries a mode (push, pop, clear) and a 64-bit key.
// Each accepted word gives exactly one output word with the popped key, its
// valid flag, a status code, the occupancy after the operation and the peak
// occupancy since reset. A clear empties the heap and keeps the peak.
// Both channels use valid/ready. in_ready_o is high only while the sequencer
// is idle, so one word is worked on at a time; a finished result sits in an
// output register, and the next word is accepted while it waits.
// At heap depth N with L = ceil(log2(N)) levels, a clear, a rejected push,
// an empty pop or an unused mode needs no key store access; a push climbs
// at most L levels and a pop descends at most L levels.
// In the sift loops every level reads the single key store port once (push)
// or at most twice (pop) and uses the one shared 64-bit comparator.
// When the receiver stalls, a second finished result waits in the sequencer
// until the output register frees; nothing is dropped.
// Reset clears occupancy, peak and all handshake state; the key store needs
// no clearing since only entries below the occupancy are read.
module binary_min_heap_queue_top #(
  parameter int unsigned DEPTH = bmhq_pkg::DefaultDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bmhq_pkg::ModeW-1:0]   mode_i,
  input  logic [bmhq_pkg::KeyW-1:0]    key_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bmhq_pkg::KeyW-1:0]    popped_key_o,
  output logic                         popped_valid_o,
  output logic [bmhq_pkg::StatusW-1:0] status_o,
  output logic [bmhq_pkg::OccW-1:0]    occupancy_o,
  output logic [bmhq_pkg::OccW-1:0]    peak_occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = AW + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_PU_UP  = 10'b00_0000_0010,
    S_PU_CMP = 10'b00_0000_0100,
    S_PO_TOP = 10'b00_0000_1000,
    S_PO_LST = 10'b00_0001_0000,
    S_PO_LFT = 10'b00_0010_0000,
    S_PO_RGT = 10'b00_0100_0000,
    S_PO_CHS = 10'b00_1000_0000,
    S_PO_DEC = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] peak_q, peak_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [bmhq_pkg::KeyW-1:0]    val_q, val_d;      // pushed key or moved key
  logic [bmhq_pkg::KeyW-1:0]    pick_q, pick_d;    // chosen child key
  logic [AW-1:0]                pidx_q, pidx_d;    // chosen child index
  logic [AW-1:0]                pos_q, pos_d;      // current hole position
  logic [bmhq_pkg::KeyW-1:0]    top_q, top_d;      // removed root key
  logic                         rvalid_q, rvalid_d;
  logic [bmhq_pkg::StatusW-1:0] rstat_q, rstat_d;
  logic [bmhq_pkg::KeyW-1:0]    okey_q, okey_d;
  logic                         opv_q, opv_d;
  logic [bmhq_pkg::StatusW-1:0] ost_q, ost_d;
  logic [bmhq_pkg::OccW-1:0]    oocc_q, oocc_d;
  logic [bmhq_pkg::OccW-1:0]    opk_q, opk_d;

  // store ports
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [bmhq_pkg::KeyW-1:0] wdata;
  logic [AW-1:0]             raddr;
  logic [bmhq_pkg::KeyW-1:0] rdata;

  // shared comparator
  logic [bmhq_pkg::KeyW-1:0] cmp_a, cmp_b;
  logic                      cmp_lt;

  // index arithmetic
  logic [AW-1:0] parent;
  logic [LW-1:0] left, right, cnt_ext;
  logic          in_acc, out_load;
  logic [CW-1:0] cnt_inc;

  bmhq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign parent  = AW'((pos_q - 1'b1) >> 1);
  assign left    = {pos_q, 1'b1};
  assign right   = left + 1'b1;
  assign cnt_ext = LW'(count_q);
  assign cnt_inc = count_q + 1'b1;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign cmp_lt = cmp_a < cmp_b;

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    peak_d   = peak_q;
    val_d    = val_q;
    pick_d   = pick_q;
    pidx_d   = pidx_q;
    pos_d    = pos_q;
    top_d    = top_q;
    rvalid_d = rvalid_q;
    rstat_d  = rstat_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = val_q;
    raddr    = '0;
    cmp_a    = val_q;
    cmp_b    = rdata;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d    = key_i;
          top_d    = '0;
          rvalid_d = 1'b0;
          rstat_d  = bmhq_pkg::ST_OK;
          state_d  = S_DONE;
          priority if (mode_i == bmhq_pkg::MODE_PUSH) begin
            if (count_q >= DepthC) begin
              rstat_d = bmhq_pkg::ST_FULL;
            end else begin
              pos_d   = count_q[AW-1:0];
              count_d = cnt_inc;
              if (cnt_inc > peak_q) begin
                peak_d = cnt_inc;
              end
              state_d = S_PU_UP;
            end
          end else if (mode_i == bmhq_pkg::MODE_POP) begin
            if (count_q == '0) begin
              rstat_d = bmhq_pkg::ST_EMPTY;
            end else begin
              count_d  = count_q - 1'b1;
              rvalid_d = 1'b1;
              raddr    = '0;
              state_d  = S_PO_TOP;
            end
          end else if (mode_i == bmhq_pkg::MODE_CLEAR) begin
            count_d = '0;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      // push: climb while the parent is greater than the key
      S_PU_UP: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          raddr   = parent;
          state_d = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        cmp_a = val_q;
        cmp_b = rdata;
        we    = 1'b1;
        if (cmp_lt) begin
          wdata   = rdata;
          pos_d   = parent;
          state_d = S_PU_UP;
        end else begin
          state_d = S_DONE;
        end
      end
      // pop: root arrives, fetch the last key
      S_PO_TOP: begin
        top_d   = rdata;
        raddr   = count_q[AW-1:0];
        state_d = S_PO_LST;
      end
      S_PO_LST: begin
        val_d   = rdata;
        pos_d   = '0;
        state_d = S_PO_LFT;
      end
      S_PO_LFT: begin
        if (left >= cnt_ext) begin
          we      = (count_q != '0);
          state_d = S_DONE;
        end else begin
          raddr   = left[AW-1:0];
          state_d = S_PO_RGT;
        end
      end
      S_PO_RGT: begin
        pick_d = rdata;
        pidx_d = left[AW-1:0];
        if (right < cnt_ext) begin
          raddr   = right[AW-1:0];
          state_d = S_PO_CHS;
        end else begin
          state_d = S_PO_DEC;
        end
      end
      // right child only when strictly smaller
      S_PO_CHS: begin
        cmp_a = rdata;
        cmp_b = pick_q;
        if (cmp_lt) begin
          pick_d = rdata;
          pidx_d = right[AW-1:0];
        end
        state_d = S_PO_DEC;
      end
      S_PO_DEC: begin
        cmp_a = pick_q;
        cmp_b = val_q;
        we    = 1'b1;
        if (cmp_lt) begin
          wdata   = pick_q;
          pos_d   = pidx_q;
          state_d = S_PO_LFT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    okey_d      = okey_q;
    opv_d       = opv_q;
    ost_d       = ost_q;
    oocc_d      = oocc_q;
    opk_d       = opk_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      okey_d      = top_q;
      opv_d       = rvalid_q;
      ost_d       = rstat_q;
      oocc_d      = bmhq_pkg::OccW'(count_q);
      opk_d       = bmhq_pkg::OccW'(peak_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload state
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    pick_q   <= pick_d;
    pidx_q   <= pidx_d;
    pos_q    <= pos_d;
    top_q    <= top_d;
    rvalid_q <= rvalid_d;
    rstat_q  <= rstat_d;
    okey_q   <= okey_d;
    opv_q    <= opv_d;
    ost_q    <= ost_d;
    oocc_q   <= oocc_d;
    opk_q    <= opk_d;
  end

  assign out_valid_o      = out_valid_q;
  assign popped_key_o     = okey_q;
  assign popped_valid_o   = opv_q;
  assign status_o         = ost_q;
  assign occupancy_o      = oocc_q;
  assign peak_occupancy_o = opk_q;

endmodule

@@ tb/binary_min_heap_queue_top_tb.sv @@
// self-checking testbench for the binary min-heap queue top level
module binary_min_heap_queue_top_tb;

  localparam int unsigned HEAP_DEPTH = bmhq_pkg::DefaultDepth;
  // unused request code, the block must leave the heap unchanged for it
  localparam logic [bmhq_pkg::ModeW-1:0] MODE_UNUSED = 2'd3;
  // slowest run is about 2000 words; the limit leaves a wide margin over it
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // cycles allowed after the last result for a stray word to show up
  localparam int unsigned TAIL_CYCLES = 60;

  typedef struct packed {
    logic [bmhq_pkg::KeyW-1:0]    popped_key;
    logic                         popped_valid;
    logic [bmhq_pkg::StatusW-1:0] status;
    logic [bmhq_pkg::OccW-1:0]    occupancy;
    logic [bmhq_pkg::OccW-1:0]    peak_occupancy;
  } heap_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [bmhq_pkg::ModeW-1:0]   mode = bmhq_pkg::MODE_PUSH;
  logic [bmhq_pkg::KeyW-1:0]    key = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [bmhq_pkg::KeyW-1:0]    popped_key;
  logic                         popped_valid;
  logic [bmhq_pkg::StatusW-1:0] status;
  logic [bmhq_pkg::OccW-1:0]    occupancy;
  logic [bmhq_pkg::OccW-1:0]    peak_occupancy;

  // shadow heap kept by the predictor
  logic [bmhq_pkg::KeyW-1:0] shadow_keys [HEAP_DEPTH];
  int unsigned               shadow_count = 0;
  int unsigned               shadow_peak = 0;

  heap_result_t pending_results[$];
  heap_result_t oldest_result;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned stall_style = 0;
  int unsigned style_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned push_count = 0;
  int unsigned pop_count = 0;
  int unsigned clear_count = 0;
  int unsigned full_count = 0;
  int unsigned empty_count = 0;
  int unsigned results_seen = 0;

  binary_min_heap_queue_top #(
    .DEPTH(HEAP_DEPTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .key_i           (key),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .popped_key_o    (popped_key),
    .popped_valid_o  (popped_valid),
    .status_o        (status),
    .occupancy_o     (occupancy),
    .peak_occupancy_o(peak_occupancy)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run-length watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("binary_min_heap_queue_top verification failed");
      $finish;
    end
  end

  // predict one operation on the shadow heap
  function automatic heap_result_t heap_predict(input logic [bmhq_pkg::ModeW-1:0] op,
                                                input logic [bmhq_pkg::KeyW-1:0] new_key);
    heap_result_t res;
    int unsigned pos;
    int unsigned up;
    int unsigned left;
    int unsigned pick;
    logic [bmhq_pkg::KeyW-1:0] moved;
    logic done;
    res = '0;
    res.status = bmhq_pkg::ST_OK;
    done = 1'b0;
    case (op)
      bmhq_pkg::MODE_PUSH: begin
        if (shadow_count >= HEAP_DEPTH) begin
          res.status = bmhq_pkg::ST_FULL;
        end else begin
          // sift up, stop on a parent less than or equal
          pos = shadow_count;
          while (pos != 0 && !done) begin
            up = (pos - 1) / 2;
            if (shadow_keys[up] <= new_key) begin
              done = 1'b1;
            end else begin
              shadow_keys[pos] = shadow_keys[up];
              pos = up;
            end
          end
          shadow_keys[pos] = new_key;
          shadow_count++;
          if (shadow_count > shadow_peak) shadow_peak = shadow_count;
        end
      end
      bmhq_pkg::MODE_POP: begin
        if (shadow_count == 0) begin
          res.status = bmhq_pkg::ST_EMPTY;
        end else begin
          res.popped_key = shadow_keys[0];
          res.popped_valid = 1'b1;
          shadow_count--;
          moved = shadow_keys[shadow_count];
          pos = 0;
          // sift down, right child only when strictly smaller
          while (!done) begin
            left = 2 * pos + 1;
            if (left >= shadow_count) begin
              done = 1'b1;
            end else begin
              pick = left;
              if (left + 1 < shadow_count && shadow_keys[left + 1] < shadow_keys[left])
                pick = left + 1;
              if (shadow_keys[pick] >= moved) begin
                done = 1'b1;
              end else begin
                shadow_keys[pos] = shadow_keys[pick];
                pos = pick;
              end
            end
          end
          if (shadow_count != 0) shadow_keys[pos] = moved;
        end
      end
      bmhq_pkg::MODE_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    res.occupancy = shadow_count[bmhq_pkg::OccW-1:0];
    res.peak_occupancy = shadow_peak[bmhq_pkg::OccW-1:0];
    return res;
  endfunction

  // random key mixing full range, small values with ties, near-max, single-bit and single-zero-bit values
  function automatic logic [bmhq_pkg::KeyW-1:0] random_key();
    logic [bmhq_pkg::KeyW-1:0] k;
    case ($urandom_range(0, 5))
      0: k = {60'd0, 4'($urandom_range(0, 15))};
      1: k = {bmhq_pkg::KeyW{1'b1}} - bmhq_pkg::KeyW'($urandom_range(0, 15));
      2: k = bmhq_pkg::KeyW'(1) << $urandom_range(0, bmhq_pkg::KeyW - 1);
      3: k = ~(bmhq_pkg::KeyW'(1) << $urandom_range(0, bmhq_pkg::KeyW - 1));
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  // offer one word, wait for the handshake, then maybe idle
  task automatic send_word(input logic [bmhq_pkg::ModeW-1:0] op,
                           input logic [bmhq_pkg::KeyW-1:0] new_key);
    heap_result_t res;
    int unsigned gap;
    @(negedge clk_i);
    in_valid <= 1'b1;
    mode <= op;
    key <= new_key;
    do @(posedge clk_i); while (!in_ready);
    res = heap_predict(op, new_key);
    pending_results.push_back(res);
    words_sent++;
    case (op)
      bmhq_pkg::MODE_PUSH:
        if (res.status == bmhq_pkg::ST_FULL) full_count++; else push_count++;
      bmhq_pkg::MODE_POP:
        if (res.status == bmhq_pkg::ST_EMPTY) empty_count++; else pop_count++;
      bmhq_pkg::MODE_CLEAR: clear_count++;
      default: ;
    endcase
    // bursts of back-to-back words with random gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        key <= {$urandom, $urandom};
        mode <= 2'($urandom_range(0, 3));
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  // receiver stall pattern, plus long hold-offs on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (style_cycles == 0) begin
        stall_style = $urandom_range(0, 3);
        style_cycles = $urandom_range(50, 300);
      end
      style_cycles--;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        case (stall_style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((cycle_count % 8) >= 3);
        endcase
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with no prediction waiting: key %h valid %b status %0d",
                 $time, popped_key, popped_valid, status);
      end else begin
        oldest_result = pending_results.pop_front();
        if (popped_key !== oldest_result.popped_key) begin
          error_count++;
          $display("%0t: popped_key expected %h actual %h", $time,
                   oldest_result.popped_key, popped_key);
        end
        if (popped_valid !== oldest_result.popped_valid) begin
          error_count++;
          $display("%0t: popped_valid expected %b actual %b", $time,
                   oldest_result.popped_valid, popped_valid);
        end
        if (status !== oldest_result.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time,
                   oldest_result.status, status);
        end
        if (occupancy !== oldest_result.occupancy) begin
          error_count++;
          $display("%0t: occupancy expected %0d actual %0d", $time,
                   oldest_result.occupancy, occupancy);
        end
        if (peak_occupancy !== oldest_result.peak_occupancy) begin
          error_count++;
          $display("%0t: peak_occupancy expected %0d actual %0d", $time,
                   oldest_result.peak_occupancy, peak_occupancy);
        end
      end
    end
  end

  // extremes, ties, every mode and the empty and clear cases
  task automatic test_directed();
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_PUSH, {bmhq_pkg::KeyW{1'b1}});
    send_word(bmhq_pkg::MODE_PUSH, '0);
    send_word(bmhq_pkg::MODE_PUSH, 64'd5);
    send_word(bmhq_pkg::MODE_PUSH, 64'd5);
    send_word(bmhq_pkg::MODE_PUSH, 64'd3);
    send_word(bmhq_pkg::MODE_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(bmhq_pkg::MODE_PUSH, 64'h5555_5555_5555_5555);
    send_word(MODE_UNUSED, {bmhq_pkg::KeyW{1'b1}});
    send_word(bmhq_pkg::MODE_POP, {bmhq_pkg::KeyW{1'b1}});
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_PUSH, 64'h8000_0000_0000_0000);
    send_word(bmhq_pkg::MODE_PUSH, 64'h0000_0000_0000_0001);
    send_word(bmhq_pkg::MODE_CLEAR, {bmhq_pkg::KeyW{1'b1}});
    send_word(bmhq_pkg::MODE_POP, '0);
    send_word(bmhq_pkg::MODE_CLEAR, '0);
    send_word(bmhq_pkg::MODE_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(bmhq_pkg::MODE_POP, '0);
  endtask

  // fill to depth, push into a full heap, then pop from a full tree
  task automatic test_fill_and_overflow();
    send_word(bmhq_pkg::MODE_CLEAR, '0);
    for (int unsigned i = 0; i < HEAP_DEPTH; i++) send_word(bmhq_pkg::MODE_PUSH, random_key());
    repeat (3) send_word(bmhq_pkg::MODE_PUSH, random_key());
    repeat (60) send_word(bmhq_pkg::MODE_POP, random_key());
    send_word(bmhq_pkg::MODE_CLEAR, random_key());
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_request = 400;
    for (int i = 0; i < 30; i++) begin
      send_word(($urandom_range(0, 2) == 0) ? bmhq_pkg::MODE_POP : bmhq_pkg::MODE_PUSH,
                random_key());
    end
  endtask

  // random mixes with a push bias that changes from chunk to chunk
  task automatic test_random_ops();
    int unsigned push_pct;
    int unsigned pick;
    for (int chunk = 0; chunk < 20; chunk++) begin
      push_pct = $urandom_range(25, 80);
      for (int i = 0; i < 40; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) send_word(bmhq_pkg::MODE_CLEAR, random_key());
        else if (pick < 4) send_word(MODE_UNUSED, random_key());
        else if (pick < 4 + push_pct) send_word(bmhq_pkg::MODE_PUSH, random_key());
        else send_word(bmhq_pkg::MODE_POP, random_key());
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_and_overflow();
    test_backpressure();
    test_random_ops();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d words in %0d cycles: %0d pushes, %0d pops, %0d clears",
             words_sent, cycle_count, push_count, pop_count, clear_count);
    $display("rejected pushes on full heap %0d, pops on empty heap %0d, results checked %0d",
             full_count, empty_count, results_seen);
    if (error_count == 0) begin
      $display("binary_min_heap_queue_top verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("binary_min_heap_queue_top verification failed");
    end
    $finish;
  end

endmodule
